// ----- hw/rtl/trapezoid_motion_profile_macros.svh -----
// Assertion macros used by the profile RTL.
`ifndef TRAPEZOID_MOTION_PROFILE_MACROS_SVH
`define TRAPEZOID_MOTION_PROFILE_MACROS_SVH

// same-cycle implication
`define TMP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("trapezoid profile check failed");

// next-cycle implication
`define TMP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("trapezoid profile check failed");

`endif

// ----- hw/rtl/tmp_pkg.sv -----
// Types and constants of the trapezoidal motion profile block.
package tmp_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int CSR_IDX_W     = 1;
   localparam int CSR_DATA_W    = 32;
   localparam int SQRT_STAGES   = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_VELOCITY = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCELERATION = 1'b1;

   typedef enum logic [1:0] {
      PH_ACCEL   = 2'd0,
      PH_CRUISE  = 2'd1,
      PH_DECEL   = 2'd2,
      PH_ARRIVED = 2'd3
   } phase_type;

   typedef struct packed {
      logic signed [31:0] start_position;
      logic signed [31:0] target_position;
      logic        [31:0] elapsed_time;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] setpoint_position;
      phase_type          phase;
   } rsp_word_type;

   // per-word context carried down the pipeline
   typedef struct packed {
      logic signed [31:0] start_position;
      logic signed [31:0] target_position;
      logic        [31:0] elapsed_time;
      logic        [31:0] velocity;
      logic        [31:0] accel;
      logic        [31:0] distance;
      logic               pos_dir;
      logic               trap;
   } eval_ctx_type;

endpackage

// ----- hw/rtl/tmp_delay.sv -----
// Shift line that carries a valid bit and side data alongside a long unit.
module tmp_delay import tmp_pkg::*; #(
   parameter int W     = 8,
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         vld_in,
   input  logic [W-1:0] dat_in,
   output logic         vld_out,
   output logic [W-1:0] dat_out
);

   logic         vld_ff [DEPTH];
   logic [W-1:0] dat_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= vld_in;
         for (int i = 1; i < DEPTH; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dat_ff[0] <= dat_in;
         for (int i = 1; i < DEPTH; i++) dat_ff[i] <= dat_ff[i-1];
      end
   end

   assign vld_out = vld_ff[DEPTH-1];
   assign dat_out = dat_ff[DEPTH-1];

endmodule

// ----- hw/rtl/tmp_sqrt.sv -----
// Pipelined integer square root of a 64-bit value, one root bit per stage.
module tmp_sqrt import tmp_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] x_in,
   output logic [31:0] root_out
);

   localparam int RW = 36;
   localparam int XW = 64;
   localparam int QW = 32;

   logic [RW-1:0] rem_ff  [SQRT_STAGES];
   logic [QW-1:0] root_ff [SQRT_STAGES];
   logic [XW-1:0] xs_ff   [SQRT_STAGES];
   logic [RW-1:0] rem_in  [SQRT_STAGES];
   logic [QW-1:0] root_in [SQRT_STAGES];
   logic [XW-1:0] xs_in   [SQRT_STAGES];

   always_comb begin
      logic [RW-1:0] rp;
      logic [RW-1:0] rs;
      logic [RW-1:0] trial;
      logic [QW-1:0] qp;
      logic [XW-1:0] xp;
      logic          ge;
      for (int i = 0; i < SQRT_STAGES; i++) begin
         if (i == 0) begin
            rp = '0;
            qp = '0;
            xp = x_in;
         end else begin
            rp = rem_ff[i-1];
            qp = root_ff[i-1];
            xp = xs_ff[i-1];
         end
         rs         = {rp[RW-3:0], xp[XW-1 -: 2]};
         trial      = RW'({qp, 2'b01});
         ge         = rs >= trial;
         rem_in[i]  = ge ? rs - trial : rs;
         root_in[i] = {qp[QW-2:0], ge};
         xs_in[i]   = {xp[XW-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < SQRT_STAGES; i++) begin
            rem_ff[i]  <= rem_in[i];
            root_ff[i] <= root_in[i];
            xs_ff[i]   <= xs_in[i];
         end
      end
   end

   assign root_out = root_ff[SQRT_STAGES-1];

endmodule

// ----- hw/rtl/tmp_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module tmp_div import tmp_pkg::*; #(
   parameter int NW = 48,
   parameter int DW = 32
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num_in,
   input  logic [DW-1:0] den_in,
   output logic [NW-1:0] quot_out
);

   logic [DW-1:0] rem_ff  [NW];
   logic [NW-1:0] num_ff  [NW];
   logic [NW-1:0] quot_ff [NW];
   logic [DW-1:0] den_ff  [NW];
   logic [DW-1:0] rem_in  [NW];
   logic [NW-1:0] num_nx  [NW];
   logic [NW-1:0] quot_in [NW];

   always_comb begin
      logic [DW-1:0] rp;
      logic [NW-1:0] np;
      logic [NW-1:0] qp;
      logic [DW-1:0] dp;
      logic [DW:0]   rs;
      logic          ge;
      for (int i = 0; i < NW; i++) begin
         if (i == 0) begin
            rp = '0;
            np = num_in;
            qp = '0;
            dp = den_in;
         end else begin
            rp = rem_ff[i-1];
            np = num_ff[i-1];
            qp = quot_ff[i-1];
            dp = den_ff[i-1];
         end
         rs         = {rp, np[NW-1]};
         ge         = rs >= {1'b0, dp};
         rem_in[i]  = ge ? DW'(rs - {1'b0, dp}) : rs[DW-1:0];
         num_nx[i]  = {np[NW-2:0], 1'b0};
         quot_in[i] = {qp[NW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= rem_in[0];
         num_ff[0]  <= num_nx[0];
         quot_ff[0] <= quot_in[0];
         den_ff[0]  <= den_in;
         for (int i = 1; i < NW; i++) begin
            rem_ff[i]  <= rem_in[i];
            num_ff[i]  <= num_nx[i];
            quot_ff[i] <= quot_in[i];
            den_ff[i]  <= den_ff[i-1];
         end
      end
   end

   assign quot_out = quot_ff[NW-1];

endmodule

// ----- hw/rtl/tmp_eval.sv -----
// Phase decision, offset products, clamping and saturated output register.
`include "trapezoid_motion_profile_macros.svh"
module tmp_eval import tmp_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  vld_in,
   input  eval_ctx_type          ctx_in,
   input  logic [31+FRAC_BITS:0] ta_in,
   input  logic [31+FRAC_BITS:0] te_in,
   input  logic [63:0]           y_in,
   output logic                  rsp_valid,
   output rsp_word_type          rsp_word
);

   localparam int TW = 32 + FRAC_BITS;
   localparam int H  = (TW + 1) / 2;
   localparam int LW = TW - H;
   localparam int SQ = 2 * FRAC_BITS + 1;

   // stage 0: end time, time compares, v*t
   logic         e0_vld_ff;
   eval_ctx_type e0_ctx_ff;
   logic [TW:0]  e0_tt_ff;
   logic         e0_le_ta_ff, e0_le_te_ff;
   logic [63:0]  e0_vt_ff, e0_y_ff;

   // stage 1: phase, time argument, cruise offset
   logic         e1_vld_ff;
   eval_ctx_type e1_ctx_ff;
   phase_type    e1_phase_ff, e1_phase_in;
   logic [TW-1:0] e1_u_ff, e1_u_in;
   logic [63:0]  e1_off1_ff, e1_off1_in;
   logic [TW:0]  e1_rem_t;
   logic [63:0]  e1_x;

   // stage 2: a*u partials
   logic         e2_vld_ff;
   eval_ctx_type e2_ctx_ff;
   phase_type    e2_phase_ff;
   logic [TW-1:0] e2_u_ff;
   logic [63:0]  e2_off1_ff;
   logic [31+H:0]  e2_au_lo_ff;
   logic [31+LW:0] e2_au_hi_ff;

   // stage 3: a*u
   logic         e3_vld_ff;
   eval_ctx_type e3_ctx_ff;
   phase_type    e3_phase_ff;
   logic [TW-1:0] e3_u_ff, e3_p_ff;
   logic [63:0]  e3_off1_ff;

   // stage 4: a*u*u partials
   logic         e4_vld_ff;
   eval_ctx_type e4_ctx_ff;
   phase_type    e4_phase_ff;
   logic [63:0]  e4_off1_ff;
   logic [TW+H-1:0]  e4_pu_lo_ff;
   logic [TW+LW-1:0] e4_pu_hi_ff;

   // stage 5: raw offset
   logic         e5_vld_ff;
   eval_ctx_type e5_ctx_ff;
   phase_type    e5_phase_ff;
   logic [63:0]  e5_off_ff, e5_off_in;
   logic [2*TW-1:0] e5_prod;

   // stage 6: clamped offset
   logic         e6_vld_ff;
   eval_ctx_type e6_ctx_ff;
   phase_type    e6_phase_ff;
   logic [31:0]  e6_off_ff;

   // output register
   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff, rsp_word_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         e0_vld_ff    <= 1'b0;
         e1_vld_ff    <= 1'b0;
         e2_vld_ff    <= 1'b0;
         e3_vld_ff    <= 1'b0;
         e4_vld_ff    <= 1'b0;
         e5_vld_ff    <= 1'b0;
         e6_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         e0_vld_ff    <= vld_in;
         e1_vld_ff    <= e0_vld_ff;
         e2_vld_ff    <= e1_vld_ff;
         e3_vld_ff    <= e2_vld_ff;
         e4_vld_ff    <= e3_vld_ff;
         e5_vld_ff    <= e4_vld_ff;
         e6_vld_ff    <= e5_vld_ff;
         rsp_valid_ff <= e6_vld_ff;
      end
   end

   always_comb begin
      e1_rem_t = e0_tt_ff - (TW+1)'(e0_ctx_ff.elapsed_time);
      priority if (e0_le_ta_ff) begin
         e1_phase_in = PH_ACCEL;
      end else if (e0_ctx_ff.trap && e0_le_te_ff) begin
         e1_phase_in = PH_CRUISE;
      end else if (!e1_rem_t[TW] || e1_rem_t == '0) begin
         e1_phase_in = PH_DECEL;
      end else begin
         e1_phase_in = PH_ARRIVED;
      end
      // deceleration runs on the time left to the end
      e1_u_in    = e0_le_ta_ff ? TW'(e0_ctx_ff.elapsed_time) : e1_rem_t[TW-1:0];
      e1_x       = e0_vt_ff >> FRAC_BITS;
      e1_off1_in = (e1_x > e0_y_ff) ? e1_x - e0_y_ff : '0;
   end

   always_comb begin
      e5_prod = ((2*TW)'(e4_pu_hi_ff) << H) + (2*TW)'(e4_pu_lo_ff);
      unique case (e4_phase_ff)
         PH_ACCEL, PH_DECEL: e5_off_in = 64'(e5_prod >> SQ);
         PH_CRUISE:          e5_off_in = e4_off1_ff;
         default:            e5_off_in = '0;
      endcase
   end

   always_comb begin
      logic               from_target;
      logic               plus;
      logic signed [33:0] base;
      logic signed [33:0] off;
      logic signed [33:0] res;
      from_target = (e6_phase_ff == PH_DECEL) || (e6_phase_ff == PH_ARRIVED);
      plus        = from_target != e6_ctx_ff.pos_dir;
      base        = from_target ? 34'(e6_ctx_ff.target_position)
                                : 34'(e6_ctx_ff.start_position);
      off         = 34'(e6_off_ff);
      res         = plus ? base + off : base - off;
      priority if (res > 34'sd2147483647) begin
         rsp_word_in.setpoint_position = 32'sh7FFFFFFF;
      end else if (res < -34'sd2147483648) begin
         rsp_word_in.setpoint_position = 32'sh80000000;
      end else begin
         rsp_word_in.setpoint_position = res[31:0];
      end
      rsp_word_in.phase = e6_phase_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e0_ctx_ff   <= ctx_in;
         e0_tt_ff    <= ctx_in.trap ? {1'b0, ta_in} + {1'b0, te_in} : {ta_in, 1'b0};
         e0_le_ta_ff <= TW'(ctx_in.elapsed_time) <= ta_in;
         e0_le_te_ff <= TW'(ctx_in.elapsed_time) <= te_in;
         e0_vt_ff    <= 64'(ctx_in.velocity) * 64'(ctx_in.elapsed_time);
         e0_y_ff     <= y_in;

         e1_ctx_ff   <= e0_ctx_ff;
         e1_phase_ff <= e1_phase_in;
         e1_u_ff     <= e1_u_in;
         e1_off1_ff  <= e1_off1_in;

         e2_ctx_ff   <= e1_ctx_ff;
         e2_phase_ff <= e1_phase_ff;
         e2_u_ff     <= e1_u_ff;
         e2_off1_ff  <= e1_off1_ff;
         e2_au_lo_ff <= (32+H)'(e1_ctx_ff.accel) * (32+H)'(e1_u_ff[H-1:0]);
         e2_au_hi_ff <= (32+LW)'(e1_ctx_ff.accel) * (32+LW)'(e1_u_ff[TW-1:H]);

         // a*u stays below 2^TW wherever the product is used
         e3_ctx_ff   <= e2_ctx_ff;
         e3_phase_ff <= e2_phase_ff;
         e3_u_ff     <= e2_u_ff;
         e3_off1_ff  <= e2_off1_ff;
         e3_p_ff     <= TW'(((32+TW)'(e2_au_hi_ff) << H) + (32+TW)'(e2_au_lo_ff));

         e4_ctx_ff   <= e3_ctx_ff;
         e4_phase_ff <= e3_phase_ff;
         e4_off1_ff  <= e3_off1_ff;
         e4_pu_lo_ff <= (TW+H)'(e3_p_ff) * (TW+H)'(e3_u_ff[H-1:0]);
         e4_pu_hi_ff <= (TW+LW)'(e3_p_ff) * (TW+LW)'(e3_u_ff[TW-1:H]);

         e5_ctx_ff   <= e4_ctx_ff;
         e5_phase_ff <= e4_phase_ff;
         e5_off_ff   <= e5_off_in;

         e6_ctx_ff   <= e5_ctx_ff;
         e6_phase_ff <= e5_phase_ff;
         e6_off_ff   <= (e5_off_ff > 64'(e5_ctx_ff.distance)) ? e5_ctx_ff.distance
                                                               : e5_off_ff[31:0];

         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `TMP_ASSERT_NOW(a_cruise_needs_trap, clock, reset, e1_vld_ff && e1_phase_ff == PH_CRUISE, e1_ctx_ff.trap)
   `TMP_ASSERT_NOW(a_offset_clamped, clock, reset, e6_vld_ff, e6_off_ff <= e6_ctx_ff.distance)
   `TMP_ASSERT_NOW(a_arrived_no_offset, clock, reset, e6_vld_ff && e6_phase_ff == PH_ARRIVED, e6_off_ff == '0)

endmodule

// ----- hw/rtl/trapezoid_motion_profile.sv -----
// Trapezoidal motion profile set-point generator, top level.
//
// req channel: one word per move query (start, target, elapsed time), valid/ready.
// rsp channel: one word per query (saturated set-point, phase), same order.
// csr port: write enable, index and data; index 0 is the cruise velocity,
// index 1 the acceleration, both unsigned Q16.16, reset to 1.0. A zero
// register value is used as one LSB. Write only while no query is in flight.
// From the accepting edge to rsp_valid the chain is input registers, a
// 32-stage square root, a bit-per-stage divider as deep as its numerator,
// then eight stages of products, clamping and saturation.
// Throughput: one word per cycle while rsp_ready is high.
// Reset clears every valid bit and loads the registers with 1.0.
// When the receiver stalls, the whole pipeline holds and req_ready drops;
// nothing is lost or repeated, and a new word is taken in the cycle the
// result is taken.
module trapezoid_motion_profile import tmp_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_word_type          req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_word_type          rsp_word,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int TW = 32 + FRAC_BITS;
   localparam int YW = 63 - FRAC_BITS;
   localparam int NW = (TW > YW) ? TW : YW;
   localparam logic [31:0] ONE_Q = 32'(1) << FRAC_BITS;

   typedef struct packed {
      eval_ctx_type ctx;
      logic [63:0]  vv;
   } sq_side_type;

   logic         adv;
   logic [31:0]  max_velocity_ff, acceleration_ff;

   logic signed [32:0] diff, ndiff;
   eval_ctx_type s0_ctx_in;
   eval_ctx_type s2_ctx_in;

   logic         s0_vld_ff, s1_vld_ff, s2_vld_ff;
   eval_ctx_type s0_ctx_ff, s1_ctx_ff, s2_ctx_ff;
   logic [63:0]  s1_da_ff, s1_vv_ff, s2_da_ff, s2_vv_ff;

   sq_side_type  sq_side_in, sq_side_out;
   logic         sq_vld;
   logic [31:0]  sq_root;

   eval_ctx_type dv_ctx_in, dv_ctx_out;
   logic         dv_vld;
   logic [NW-1:0] ta_q, te_q, y_q;

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_velocity_ff <= ONE_Q;
         acceleration_ff <= ONE_Q;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_VELOCITY: max_velocity_ff <= csr_wdata;
            CSR_ACCELERATION: acceleration_ff <= csr_wdata;
         endcase
      end
   end

   always_comb begin
      diff  = 33'(req_word.target_position) - 33'(req_word.start_position);
      ndiff = -diff;
      s0_ctx_in.start_position  = req_word.start_position;
      s0_ctx_in.target_position = req_word.target_position;
      s0_ctx_in.elapsed_time    = req_word.elapsed_time;
      s0_ctx_in.velocity = (max_velocity_ff == '0) ? 32'd1 : max_velocity_ff;
      s0_ctx_in.accel    = (acceleration_ff == '0) ? 32'd1 : acceleration_ff;
      // zero distance counts as the negative direction
      s0_ctx_in.pos_dir  = diff > 33'sd0;
      s0_ctx_in.distance = s0_ctx_in.pos_dir ? diff[31:0] : ndiff[31:0];
      s0_ctx_in.trap     = 1'b0;
   end

   always_comb begin
      s2_ctx_in      = s1_ctx_ff;
      s2_ctx_in.trap = s1_da_ff > s1_vv_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s0_vld_ff <= req_valid;
         s1_vld_ff <= s0_vld_ff;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ctx_ff <= s0_ctx_in;
         s1_ctx_ff <= s0_ctx_ff;
         s1_da_ff  <= 64'(s0_ctx_ff.distance) * 64'(s0_ctx_ff.accel);
         s1_vv_ff  <= 64'(s0_ctx_ff.velocity) * 64'(s0_ctx_ff.velocity);
         s2_ctx_ff <= s2_ctx_in;
         s2_da_ff  <= s1_da_ff;
         s2_vv_ff  <= s1_vv_ff;
      end
   end

   assign sq_side_in.ctx = s2_ctx_ff;
   assign sq_side_in.vv  = s2_vv_ff;

   tmp_sqrt u_sqrt (
      .clock    (clock),
      .en       (adv),
      .x_in     (s2_da_ff),
      .root_out (sq_root)
   );

   tmp_delay #(.W($bits(sq_side_type)), .DEPTH(SQRT_STAGES)) u_sqrt_side (
      .clock   (clock),
      .reset   (reset),
      .en      (adv),
      .vld_in  (s2_vld_ff),
      .dat_in  (sq_side_in),
      .vld_out (sq_vld),
      .dat_out (sq_side_out)
   );

   // triangle profile peaks at the root instead of the cruise limit
   always_comb begin
      dv_ctx_in = sq_side_out.ctx;
      dv_ctx_in.velocity = sq_side_out.ctx.trap ? sq_side_out.ctx.velocity : sq_root;
   end

   tmp_div #(.NW(NW), .DW(32)) u_div_ta (
      .clock    (clock),
      .en       (adv),
      .num_in   (NW'(64'(dv_ctx_in.velocity) << FRAC_BITS)),
      .den_in   (sq_side_out.ctx.accel),
      .quot_out (ta_q)
   );

   tmp_div #(.NW(NW), .DW(32)) u_div_te (
      .clock    (clock),
      .en       (adv),
      .num_in   (NW'(64'(sq_side_out.ctx.distance) << FRAC_BITS)),
      .den_in   (sq_side_out.ctx.velocity),
      .quot_out (te_q)
   );

   tmp_div #(.NW(NW), .DW(32)) u_div_y (
      .clock    (clock),
      .en       (adv),
      .num_in   (NW'(sq_side_out.vv >> (FRAC_BITS + 1))),
      .den_in   (sq_side_out.ctx.accel),
      .quot_out (y_q)
   );

   tmp_delay #(.W($bits(eval_ctx_type)), .DEPTH(NW)) u_div_side (
      .clock   (clock),
      .reset   (reset),
      .en      (adv),
      .vld_in  (sq_vld),
      .dat_in  (dv_ctx_in),
      .vld_out (dv_vld),
      .dat_out (dv_ctx_out)
   );

   tmp_eval #(.FRAC_BITS(FRAC_BITS)) u_eval (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .vld_in    (dv_vld),
      .ctx_in    (dv_ctx_out),
      .ta_in     (ta_q[TW-1:0]),
      .te_in     (te_q[TW-1:0]),
      .y_in      (64'(y_q)),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule
